FILE: hdl/mtflru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtflru_pkg
// Shared types and constants for the move-to-front LRU tag cache.
// ----------------------------------------------------------------------------
package mtflru_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int CODE_W          = 16;
    localparam int FONT_W          = 8;
    localparam int SLOT_OUT_W      = 4;

    typedef struct packed {
        logic [CODE_W-1:0] glyph_code;
        logic [FONT_W-1:0] font_id;
    } lookup_word_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  evicted_valid;
    } result_word_t;

    localparam int TAG_W = $bits(lookup_word_t);

    typedef struct packed {
        logic load;
        logic walk;
        logic shift;
        logic head;
        logic out_load;
    } mtflru_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic walk_front;
        logic shift_last;
        logic out_free;
    } mtflru_stat_t;

endpackage
`default_nettype wire

FILE: hdl/mtflru_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtflru_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mtflru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hdl/mtflru_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtflru_ctrl
// Sequencer: accept, walk the recency list, shift it, write the head, reply.
// ----------------------------------------------------------------------------
module mtflru_ctrl
    import mtflru_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         lookup_valid,
    output logic              lookup_stall,
    input  wire mtflru_stat_t stat,
    output mtflru_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        lookup_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (lookup_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = stat.walk_front ? S_HEAD : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/mtflru_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtflru_dp
// Tag and recency RAMs, walk and shift pipelines, valid bits, result register.
// ----------------------------------------------------------------------------
module mtflru_dp
    import mtflru_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mtflru_cmd_t  cmd,
    output mtflru_stat_t      stat,
    input  wire lookup_word_t lookup,
    input  wire logic         result_stall,
    output logic              result_valid,
    output result_word_t      result
);

    localparam int SLOT_W = $clog2(NUM_ENTRIES);
    localparam logic [SLOT_W-1:0] LAST_POS  = SLOT_W'(NUM_ENTRIES - 1);
    localparam logic [SLOT_W-1:0] FIRST_POS = '0;
    localparam logic [SLOT_W-1:0] ONE       = SLOT_W'(1);

    logic [TAG_W-1:0]       key_reg, key_next;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] pw_reg, pw_next;     // recency position written

    logic              iss_on_reg, iss_on_next;
    logic [SLOT_W-1:0] iss_pos_reg, iss_pos_next;
    logic              s1_on_reg, s1_on_next;
    logic [SLOT_W-1:0] s1_pos_reg, s1_pos_next;
    logic              s1_wr_reg, s1_wr_next;
    logic              s2_on_reg, s2_on_next;
    logic [SLOT_W-1:0] s2_pos_reg, s2_pos_next;
    logic [SLOT_W-1:0] s2_slot_reg, s2_slot_next;

    logic              res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_evict_reg, res_evict_next;

    logic              shf_rd_on_reg, shf_rd_on_next;
    logic [SLOT_W-1:0] shf_rd_reg, shf_rd_next;
    logic              shf_wr_on_reg, shf_wr_on_next;
    logic [SLOT_W-1:0] shf_wr_addr_reg, shf_wr_addr_next;
    logic              shf_wr_pw_reg, shf_wr_pw_next;

    logic         out_valid_reg, out_valid_next;
    result_word_t out_word_reg, out_word_next;

    logic [SLOT_W-1:0] ord_rd_addr, ord_rd_data, ord_wr_addr, ord_wr_data;
    logic              ord_wr_en;
    logic [SLOT_W-1:0] tag_rd_addr, tag_wr_addr;
    logic [TAG_W-1:0]  tag_rd_data, tag_wr_data;
    logic              tag_wr_en;

    logic [SLOT_W-1:0] s1_slot;
    logic              hit_now, end_now, walk_done;

    mtflru_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_ENTRIES)
    ) u_order_ram (
        .clk     (clk),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data),
        .rd_addr (ord_rd_addr),
        .rd_data (ord_rd_data)
    );

    mtflru_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_wr_data),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    // unwritten recency position p holds slot p
    assign s1_slot   = s1_wr_reg ? ord_rd_data : s1_pos_reg;
    assign hit_now   = s2_on_reg && valid_reg[s2_slot_reg] && (tag_rd_data == key_reg);
    assign end_now   = s2_on_reg && (s2_pos_reg == LAST_POS);
    assign walk_done = hit_now || end_now;

    assign stat.walk_done  = walk_done;
    assign stat.walk_front = (s2_pos_reg == FIRST_POS);
    assign stat.shift_last = shf_wr_on_reg && !shf_rd_on_reg;
    assign stat.out_free   = !out_valid_reg || !result_stall;

    assign ord_rd_addr = cmd.shift ? shf_rd_reg : iss_pos_reg;
    assign tag_rd_addr = s1_slot;
    assign tag_wr_en   = cmd.walk && walk_done && !hit_now;
    assign tag_wr_addr = s2_slot_reg;
    assign tag_wr_data = key_reg;

    always_comb
    begin
        ord_wr_en   = 1'b0;
        ord_wr_addr = FIRST_POS;
        ord_wr_data = res_slot_reg;
        if (cmd.head)
        begin
            ord_wr_en = 1'b1;
        end
        else if (cmd.shift && shf_wr_on_reg)
        begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = shf_wr_addr_reg;
            ord_wr_data = shf_wr_pw_reg ? ord_rd_data : (shf_wr_addr_reg - ONE);
        end
    end

    always_comb
    begin
        key_next         = key_reg;
        valid_next       = valid_reg;
        pw_next          = pw_reg;
        iss_on_next      = iss_on_reg;
        iss_pos_next     = iss_pos_reg;
        s1_on_next       = s1_on_reg;
        s1_pos_next      = s1_pos_reg;
        s1_wr_next       = s1_wr_reg;
        s2_on_next       = s2_on_reg;
        s2_pos_next      = s2_pos_reg;
        s2_slot_next     = s2_slot_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_evict_next   = res_evict_reg;
        shf_rd_on_next   = shf_rd_on_reg;
        shf_rd_next      = shf_rd_reg;
        shf_wr_on_next   = shf_wr_on_reg;
        shf_wr_addr_next = shf_wr_addr_reg;
        shf_wr_pw_next   = shf_wr_pw_reg;
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;

        if (cmd.load)
        begin
            key_next     = lookup;
            iss_on_next  = 1'b1;
            iss_pos_next = FIRST_POS;
            s1_on_next   = 1'b0;
            s2_on_next   = 1'b0;
        end

        if (cmd.walk)
        begin
            s1_on_next   = iss_on_reg;
            s1_pos_next  = iss_pos_reg;
            s1_wr_next   = pw_reg[iss_pos_reg];
            s2_on_next   = s1_on_reg;
            s2_pos_next  = s1_pos_reg;
            s2_slot_next = s1_slot;
            if (iss_on_reg)
            begin
                iss_pos_next = iss_pos_reg + ONE;
                if (iss_pos_reg == LAST_POS)
                begin
                    iss_on_next = 1'b0;
                end
            end
            if (walk_done)
            begin
                iss_on_next    = 1'b0;
                s1_on_next     = 1'b0;
                s2_on_next     = 1'b0;
                res_hit_next   = hit_now;
                res_slot_next  = s2_slot_reg;
                res_evict_next = !hit_now && valid_reg[s2_slot_reg];
                if (!hit_now)
                begin
                    valid_next[s2_slot_reg] = 1'b1;
                end
                shf_rd_on_next = (s2_pos_reg != FIRST_POS);
                shf_rd_next    = s2_pos_reg - ONE;
                shf_wr_on_next = 1'b0;
            end
        end

        if (cmd.shift)
        begin
            shf_wr_on_next   = shf_rd_on_reg;
            shf_wr_addr_next = shf_rd_reg + ONE;
            shf_wr_pw_next   = pw_reg[shf_rd_reg];
            if (shf_rd_on_reg)
            begin
                shf_rd_next = shf_rd_reg - ONE;
                if (shf_rd_reg == FIRST_POS)
                begin
                    shf_rd_on_next = 1'b0;
                end
            end
            if (shf_wr_on_reg)
            begin
                pw_next[shf_wr_addr_reg] = 1'b1;
            end
        end

        if (cmd.head)
        begin
            pw_next[FIRST_POS] = 1'b1;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next              = 1'b1;
            out_word_next.hit           = res_hit_reg;
            out_word_next.slot_index    = SLOT_OUT_W'(res_slot_reg);
            out_word_next.evicted_valid = res_evict_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            pw_reg          <= '0;
            iss_on_reg      <= 1'b0;
            iss_pos_reg     <= '0;
            s1_on_reg       <= 1'b0;
            s1_pos_reg      <= '0;
            s1_wr_reg       <= 1'b0;
            s2_on_reg       <= 1'b0;
            s2_pos_reg      <= '0;
            s2_slot_reg     <= '0;
            res_hit_reg     <= 1'b0;
            res_slot_reg    <= '0;
            res_evict_reg   <= 1'b0;
            shf_rd_on_reg   <= 1'b0;
            shf_rd_reg      <= '0;
            shf_wr_on_reg   <= 1'b0;
            shf_wr_addr_reg <= '0;
            shf_wr_pw_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            pw_reg          <= pw_next;
            iss_on_reg      <= iss_on_next;
            iss_pos_reg     <= iss_pos_next;
            s1_on_reg       <= s1_on_next;
            s1_pos_reg      <= s1_pos_next;
            s1_wr_reg       <= s1_wr_next;
            s2_on_reg       <= s2_on_next;
            s2_pos_reg      <= s2_pos_next;
            s2_slot_reg     <= s2_slot_next;
            res_hit_reg     <= res_hit_next;
            res_slot_reg    <= res_slot_next;
            res_evict_reg   <= res_evict_next;
            shf_rd_on_reg   <= shf_rd_on_next;
            shf_rd_reg      <= shf_rd_next;
            shf_wr_on_reg   <= shf_wr_on_next;
            shf_wr_addr_reg <= shf_wr_addr_next;
            shf_wr_pw_reg   <= shf_wr_pw_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

`ifndef NO_ASSERTIONS
    // miss retags the tail entry and marks it valid
    a_miss_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && walk_done && !hit_now) |=> (valid_reg[res_slot_reg] && !res_hit_reg))
        else $error("miss did not leave a valid entry");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && hit_now) |=> (res_hit_reg && !res_evict_reg))
        else $error("hit reported an eviction");

    a_head_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head |-> !shf_rd_on_reg)
        else $error("head written while shift reads pending");

    a_shift_not_front: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && shf_wr_on_reg) |-> (shf_wr_addr_reg != FIRST_POS))
        else $error("shift wrote the front position");
`endif

endmodule
`default_nettype wire

FILE: hdl/move_to_front_lru_tag_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_lru_tag_cache_core
// Fully associative glyph/font tag cache with move-to-front replacement.
//
// Lookup channel: lookup_valid/lookup_stall carry one word {glyph_code,
// font_id}. Result channel: result_valid/result_stall carry one word
// {hit, slot_index, evicted_valid} per lookup, in order.
// A lookup walks the recency list front to back through the order and tag
// RAMs, one position a cycle through the issue, s1 and s2 stages; a hit at
// position P, or a miss (P = NUM_ENTRIES-1), then shifts positions P..1 back
// through the order RAM, one per cycle, and writes the slot to the front.
// One lookup is in flight at a time; the next is accepted the cycle after
// its result is registered, even while that result waits on result_stall.
// A stalled result holds until taken, and the block waits before loading
// the next one.
// Reset: all entries invalid, recency order slot i at position i; no
// clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module move_to_front_lru_tag_cache_core
    import mtflru_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         lookup_valid,
    output logic              lookup_stall,
    input  wire lookup_word_t lookup,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_word_t      result
);

    mtflru_cmd_t  cmd;
    mtflru_stat_t stat;

    mtflru_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup_valid),
        .lookup_stall (lookup_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    mtflru_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .lookup       (lookup),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the move-to-front LRU tag cache.
// A scoreboard keeps its own copy of the tag store and recency list. Each
// accepted lookup word is run through it, and the expected result word goes
// into a queue. Each result word taken from the block is checked field by
// field against the oldest queued word. A fixed table of lookups covers reset,
// the extreme tag values, hits at the front, middle and tail, and eviction of
// a valid entry. Random lookups from a small working set then follow, under
// three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_top
    import mtflru_pkg::*;
();

    localparam int ENTRIES = NUM_ENTRIES_DEF;
    localparam int RAND_PER_PHASE = 534;
    localparam int POOL_SIZE = 24;

    typedef struct {
        lookup_word_t word;
        bit           known;
        result_word_t res;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         lookup_valid = 1'b0;
    logic         lookup_stall;
    lookup_word_t lookup = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    logic [CODE_W-1:0] cache_code [ENTRIES];
    logic [FONT_W-1:0] cache_font [ENTRIES];
    logic              cache_live [ENTRIES];
    logic [3:0]        lru_order  [ENTRIES];

    result_word_t pending_results [$];
    dir_row_t     dir_rows [$];
    lookup_word_t tag_pool [POOL_SIZE];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_cnt = 0;

    move_to_front_lru_tag_cache_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup_valid),
        .lookup_stall (lookup_stall),
        .lookup       (lookup),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    // Walk the recency list front to back, promote the matching entry or
    // retag the tail entry.
    function automatic result_word_t lru_lookup(input lookup_word_t w);
        result_word_t r;
        int           pos;
        int           match_pos;
        logic [3:0]   slot;
        r = '0;
        match_pos = ENTRIES - 1;
        for (pos = 0; pos < ENTRIES; pos++)
        begin
            if (!r.hit && cache_live[lru_order[pos]] &&
                cache_code[lru_order[pos]] == w.glyph_code &&
                cache_font[lru_order[pos]] == w.font_id)
            begin
                r.hit = 1'b1;
                match_pos = pos;
            end
        end
        slot = lru_order[match_pos];
        for (pos = match_pos; pos > 0; pos--)
            lru_order[pos] = lru_order[pos-1];
        lru_order[0] = slot;
        r.slot_index = slot;
        if (!r.hit)
        begin
            r.evicted_valid = cache_live[slot];
            cache_code[slot] = w.glyph_code;
            cache_font[slot] = w.font_id;
            cache_live[slot] = 1'b1;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [CODE_W-1:0] code,
                                    input logic [FONT_W-1:0] font,
                                    input bit known, input bit hit,
                                    input logic [3:0] slot, input bit evicted);
        dir_row_t row;
        row.word = '{glyph_code: code, font_id: font};
        row.known = known;
        row.res = '{hit: hit, slot_index: slot, evicted_valid: evicted};
        dir_rows.push_back(row);
    endfunction

    // Mostly reuse of a small working set, some near misses, some fresh tags.
    function automatic lookup_word_t random_word();
        lookup_word_t w;
        int           roll;
        roll = $urandom_range(0, 99);
        w = tag_pool[$urandom_range(0, POOL_SIZE-1)];
        if (roll >= 80)
        begin
            w.glyph_code = CODE_W'($urandom_range(0, 16'hFFFF));
            w.font_id = FONT_W'($urandom_range(0, 8'hFF));
            tag_pool[$urandom_range(0, POOL_SIZE-1)] = w;
        end
        else if (roll >= 65)
        begin
            if ($urandom_range(0, 1))
                w.font_id = FONT_W'($urandom_range(0, 8'hFF));
            else
                w.glyph_code = w.glyph_code ^ (16'h1 << $urandom_range(0, CODE_W-1));
        end
        return w;
    endfunction

    task automatic send_word(input lookup_word_t w, input bit known,
                             input result_word_t typed);
        result_word_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            lookup_valid <= 1'b0;
            @(posedge clk);
        end
        lookup_valid <= 1'b1;
        lookup <= w;
        do
            @(posedge clk);
        while (lookup_stall);
        predicted = lru_lookup(w);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic drain_results();
        lookup_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word: hit=%0b slot=%0d evicted=%0b",
                             result.hit, result.slot_index, result.evicted_valid);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.hit !== want.hit || result.slot_index !== want.slot_index ||
                    result.evicted_valid !== want.evicted_valid)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp hit/slot/ev=%0b/%0d/%0b got %0b/%0d/%0b",
                                 want.hit, want.slot_index, want.evicted_valid,
                                 result.hit, result.slot_index, result.evicted_valid);
                end
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin
        #(12 * 600000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int i;
        int ph;
        for (i = 0; i < ENTRIES; i++)
        begin
            cache_code[i] = '0;
            cache_font[i] = '0;
            cache_live[i] = 1'b0;
            lru_order[i] = 4'(i);
        end
        for (i = 0; i < POOL_SIZE; i++)
        begin
            tag_pool[i].glyph_code = CODE_W'($urandom_range(0, 16'hFFFF));
            tag_pool[i].font_id = FONT_W'($urandom_range(0, 8'hFF));
        end

        // reset contents never hit; misses take the tail, slots 15 down to 0
        add_row(16'h0000, 8'h00, 1, 0, 15, 0);
        add_row(16'h0000, 8'h00, 1, 1, 15, 0);
        add_row(16'hFFFF, 8'hFF, 1, 0, 14, 0);
        add_row(16'hFFFF, 8'h00, 1, 0, 13, 0);
        add_row(16'h0000, 8'hFF, 1, 0, 12, 0);
        add_row(16'hFFFF, 8'hFF, 1, 1, 14, 0);
        add_row(16'h0000, 8'h00, 1, 1, 15, 0);
        for (i = 0; i < 12; i++)
            add_row(16'h1000 + 16'(i), 8'hA5, 1, 0, 4'(11 - i), 0);
        // cache full: evict a valid entry, then hit at the tail
        add_row(16'h8000, 8'h80, 1, 0, 13, 1);
        add_row(16'h0000, 8'hFF, 1, 1, 12, 0);
        add_row(16'h1000, 8'hA5, 1, 1, 11, 0);
        add_row(16'hFFFF, 8'h00, 1, 0, 14, 1);
        add_row(16'h1000, 8'hA4, 0, 0, 0, 0);
        add_row(16'h5555, 8'h55, 0, 0, 0, 0);
        add_row(16'hAAAA, 8'hAA, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
            send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].res);

        for (ph = 0; ph < 3; ph++)
        begin
            drain_results();
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 61 : 0;
            recv_stall_pct = (ph == 0) ? 61 : (ph == 1) ? 14 : 0;
            for (i = 0; i < RAND_PER_PHASE; i++)
                send_word(random_word(), 0, '0);
        end

        drain_results();
        repeat (2 * ENTRIES + 10) @(posedge clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
hdl/mtflru_pkg.sv
hdl/mtflru_ram.sv
hdl/mtflru_ctrl.sv
hdl/mtflru_dp.sv
hdl/move_to_front_lru_tag_cache_core.sv
test/tb_top.sv
